// File: hdl/bpm_pkg.sv
// Shared constants, codes and types of the battery power monitor and charger.
package bpm_pkg;

    localparam int SAMPLE_SHIFT = 4;
    localparam int ADC_BITS     = 12;

    localparam int SUM_W    = ADC_BITS + SAMPLE_SHIFT;
    localparam int CNT_W    = SAMPLE_SHIFT + 1;
    localparam int WIN_LAST = (1 << SAMPLE_SHIFT) - 1;

    localparam int MV_W          = 13;
    localparam int MV_MAX        = (1 << MV_W) - 1;
    localparam int SCALE_W       = ADC_BITS + 4;
    localparam int RECIP_SHIFT   = SCALE_W + 4;
    localparam int RECIP         = ((1 << RECIP_SHIFT) + 9) / 10;
    localparam int PROD_W        = 2 * SCALE_W + 1;
    localparam int QUOT_W        = SCALE_W - 3;
    localparam int QUOT_WIDE_W   = (QUOT_W > MV_W + 1) ? QUOT_W : MV_W + 1;
    localparam int SCALE_MUL     = 11;
    localparam int SCALE_ROUND   = 5;

    localparam int TICK_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BAT_CHECK_EN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AC_CHECK_EN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AC_TIMEOUT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHARGE_HOLD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_THR      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHARGE_THR    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEEP_THR      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ABSENT_THR    = 3'd7;

    localparam logic [2:0] BAT_OFF           = 3'd0;
    localparam logic [2:0] BAT_NOT_CONNECTED = 3'd1;
    localparam logic [2:0] BAT_DEPLETED      = 3'd2;
    localparam logic [2:0] BAT_ATTN          = 3'd3;
    localparam logic [2:0] BAT_CHARGING      = 3'd4;
    localparam logic [2:0] BAT_FULL          = 3'd5;

    localparam logic [1:0] DC_UNKNOWN = 2'd0;
    localparam logic [1:0] DC_OK      = 2'd1;
    localparam logic [1:0] DC_FAILED  = 2'd2;

    localparam logic [1:0] AC_OK        = 2'd0;
    localparam logic [1:0] AC_FAULT     = 2'd1;
    localparam logic [1:0] AC_CHECK_OFF = 2'd2;

    localparam logic [1:0] FSM_CONNECT       = 2'd0;
    localparam logic [1:0] FSM_CHARGE        = 2'd1;
    localparam logic [1:0] FSM_CHARGE_END    = 2'd2;
    localparam logic [1:0] FSM_NOT_CONNECTED = 2'd3;

    typedef struct packed {
        logic [ADC_BITS-1:0] adc_sample;
        logic                dc_ok_pin;
        logic                dc_fault_pin;
        logic                ac_pin;
    } t_bpm_in;

    typedef struct packed {
        logic [MV_W-1:0] battery_mv;
        logic [2:0]      battery_status;
        logic [1:0]      dc_status;
        logic [1:0]      ac_status;
        logic [1:0]      charger_state;
        logic            charger_on;
        logic            measure_done;
    } t_bpm_out;

    typedef struct packed {
        logic              battery_check_enable;
        logic              ac_check_enable;
        logic [TICK_W-1:0] ac_timeout_ticks;
        logic [TICK_W-1:0] charge_hold_ticks;
        logic [MV_W-1:0]   full_threshold_mv;
        logic [MV_W-1:0]   charge_threshold_mv;
        logic [MV_W-1:0]   deep_threshold_mv;
        logic [MV_W-1:0]   absent_threshold_mv;
    } t_bpm_cfg;

    typedef struct packed {
        logic [MV_W-1:0] mv;
        logic [2:0]      code;
        logic            done;
    } t_bpm_bat;

endpackage

// File: hdl/bpm_in_if.sv
// Request channel carrying one tick: converter sample and status pins.
interface bpm_in_if import bpm_pkg::*; ();
    logic    valid;
    logic    ready;
    t_bpm_in payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/bpm_out_if.sv
// Result channel carrying the monitor and charger status after one tick.
interface bpm_out_if import bpm_pkg::*; ();
    logic     valid;
    logic     ready;
    t_bpm_out payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/battery_power_monitor_charger_top.sv
// Battery, mains and inverter monitor with charger control: top level.
// One request per tick carries a converter sample and the DC ok, DC fault and AC
// pins; each request gives exactly one result holding the averaged battery
// voltage in mV, the battery, DC and AC status codes, the charger state, the
// charger enable level and a flag for a closed averaging window. The block takes
// one request every clock while the output takes results: a request is held in an
// input register, and the whole tick update (window sum, scale by 11/10, threshold
// tests, pin tracking, charger machine) runs in one pass into the result register,
// which offers the result; the rate is one per clock while results are taken, set
// by that single-pass state update. The input register can take a new request while
// a finished result waits. Write configuration only while no request is in flight.
module battery_power_monitor_charger_top import bpm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bpm_in_if.sink                i_bpm_in,
    bpm_out_if.source             o_bpm_out
);

    t_bpm_cfg          r_cfg;
    logic              r_in_valid;
    t_bpm_in           r_in;
    logic              r_out_valid;
    t_bpm_out          r_out;
    logic [1:0]        r_dc_code, n_dc_code;
    logic [1:0]        r_ac_code, n_ac_code;
    logic [TICK_W-1:0] r_ac_cnt, n_ac_cnt;
    logic [1:0]        r_fsm, n_fsm;
    logic [TICK_W-1:0] r_hold, n_hold;
    logic              r_drive, n_drive;
    logic              advance;
    t_bpm_bat          bat;
    logic [TICK_W-1:0] ac_cnt_inc;
    logic [TICK_W-1:0] hold_inc;

    assign advance        = r_in_valid && (!r_out_valid || o_bpm_out.ready);
    assign i_bpm_in.ready = !r_in_valid || advance;
    assign o_bpm_out.valid   = r_out_valid;
    assign o_bpm_out.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.battery_check_enable <= 1'b1;
            r_cfg.ac_check_enable      <= 1'b1;
            r_cfg.ac_timeout_ticks     <= TICK_W'(200);
            r_cfg.charge_hold_ticks    <= TICK_W'(1000);
            r_cfg.full_threshold_mv    <= MV_W'(2720);
            r_cfg.charge_threshold_mv  <= MV_W'(2100);
            r_cfg.deep_threshold_mv    <= MV_W'(1850);
            r_cfg.absent_threshold_mv  <= MV_W'(1500);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BAT_CHECK_EN: r_cfg.battery_check_enable <= i_cfg_data[0];
                REG_AC_CHECK_EN:  r_cfg.ac_check_enable      <= i_cfg_data[0];
                REG_AC_TIMEOUT:   r_cfg.ac_timeout_ticks     <= i_cfg_data[TICK_W-1:0];
                REG_CHARGE_HOLD:  r_cfg.charge_hold_ticks    <= i_cfg_data[TICK_W-1:0];
                REG_FULL_THR:     r_cfg.full_threshold_mv    <= i_cfg_data[MV_W-1:0];
                REG_CHARGE_THR:   r_cfg.charge_threshold_mv  <= i_cfg_data[MV_W-1:0];
                REG_DEEP_THR:     r_cfg.deep_threshold_mv    <= i_cfg_data[MV_W-1:0];
                REG_ABSENT_THR:   r_cfg.absent_threshold_mv  <= i_cfg_data[MV_W-1:0];
                default: ;
            endcase
        end
    end

    bpm_battery u_battery (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_sample (r_in.adc_sample),
        .i_cfg    (r_cfg),
        .o_bat    (bat)
    );

    // DC and AC status
    always_comb begin
        n_dc_code = r_dc_code;
        if (r_in.dc_ok_pin && !r_in.dc_fault_pin) begin
            n_dc_code = DC_OK;
        end else if (!r_in.dc_ok_pin && r_in.dc_fault_pin) begin
            n_dc_code = DC_FAILED;
        end

        n_ac_code  = r_in.ac_pin ? r_ac_code : AC_OK;
        ac_cnt_inc = (r_in.ac_pin ? r_ac_cnt : '0) + TICK_W'(1);
        n_ac_cnt   = ac_cnt_inc;
        if (ac_cnt_inc >= r_cfg.ac_timeout_ticks) begin
            n_ac_cnt  = '0;
            n_ac_code = AC_FAULT;
        end
        if (!r_cfg.ac_check_enable) begin
            n_ac_code = AC_CHECK_OFF;
        end
    end

    // Charger machine
    always_comb begin
        n_fsm    = r_fsm;
        n_hold   = r_hold;
        n_drive  = r_drive;
        hold_inc = (r_hold != '1) ? r_hold + TICK_W'(1) : r_hold;
        unique case (r_fsm)
            FSM_CONNECT: begin
                if (bat.code == BAT_ATTN || bat.code == BAT_CHARGING) begin
                    n_fsm = FSM_CHARGE;
                end else if (bat.code == BAT_NOT_CONNECTED) begin
                    n_fsm = FSM_NOT_CONNECTED;
                end
            end
            FSM_CHARGE: begin
                n_drive = 1'b1;
                if (bat.code == BAT_FULL) begin
                    n_fsm  = FSM_CHARGE_END;
                    n_hold = '0;
                end else if (bat.code == BAT_NOT_CONNECTED) begin
                    n_fsm = FSM_NOT_CONNECTED;
                end
            end
            FSM_CHARGE_END: begin
                n_drive = 1'b0;
                n_hold  = hold_inc;
                if (hold_inc >= r_cfg.charge_hold_ticks) begin
                    if (bat.code != BAT_FULL) begin
                        n_fsm = FSM_CONNECT;
                    end else begin
                        n_hold = '0;
                    end
                end
            end
            FSM_NOT_CONNECTED: begin
                n_drive = 1'b0;
                if (bat.code != BAT_NOT_CONNECTED) begin
                    n_fsm = FSM_CONNECT;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_dc_code   <= DC_UNKNOWN;
            r_ac_code   <= AC_OK;
            r_ac_cnt    <= '0;
            r_fsm       <= FSM_CONNECT;
            r_hold      <= '0;
            r_drive     <= 1'b0;
        end else begin
            if (i_bpm_in.valid && i_bpm_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_dc_code   <= n_dc_code;
                r_ac_code   <= n_ac_code;
                r_ac_cnt    <= n_ac_cnt;
                r_fsm       <= n_fsm;
                r_hold      <= n_hold;
                r_drive     <= n_drive;
            end else if (o_bpm_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: hold the request and the result
    always_ff @(posedge i_clk) begin
        if (i_bpm_in.valid && i_bpm_in.ready) begin
            r_in <= i_bpm_in.payload;
        end
        if (advance) begin
            r_out.battery_mv     <= bat.mv;
            r_out.battery_status <= bat.code;
            r_out.dc_status      <= n_dc_code;
            r_out.ac_status      <= n_ac_code;
            r_out.charger_state  <= n_fsm;
            r_out.charger_on     <= n_drive;
            r_out.measure_done   <= bat.done;
        end
    end

endmodule

// File: hdl/bpm_battery.sv
// Battery path: sample window accumulation, scaling to millivolts and classification.
module bpm_battery import bpm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [ADC_BITS-1:0] i_sample,
    input  t_bpm_cfg            i_cfg,
    output t_bpm_bat            o_bat
);

    logic [SUM_W-1:0]       r_sum, n_sum;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [MV_W-1:0]        r_mv, n_mv;
    logic [2:0]             r_code, n_code;
    logic                   close_win;
    logic [SUM_W-1:0]       sum_all;
    logic [ADC_BITS-1:0]    avg;
    logic [SCALE_W-1:0]     scaled;
    logic [PROD_W-1:0]      prod;
    logic [QUOT_W-1:0]      quot;
    logic [QUOT_WIDE_W-1:0] quot_wide;
    logic [MV_W-1:0]        mv_sat;
    logic [2:0]             class_code;

    always_comb begin
        sum_all   = r_sum + SUM_W'(i_sample);
        close_win = (r_cnt == CNT_W'(WIN_LAST));
        avg       = sum_all[SUM_W-1:SAMPLE_SHIFT];
        scaled    = (SCALE_W'(avg) << 3) + (SCALE_W'(avg) << 1) + SCALE_W'(avg)
                    + SCALE_W'(SCALE_ROUND);
        prod      = PROD_W'(scaled) * PROD_W'(RECIP);
        quot      = prod[RECIP_SHIFT +: QUOT_W];
        quot_wide = QUOT_WIDE_W'(quot);
        mv_sat    = (quot_wide > QUOT_WIDE_W'(MV_MAX)) ? MV_W'(MV_MAX)
                                                       : quot_wide[MV_W-1:0];
    end

    always_comb begin
        priority if (!i_cfg.battery_check_enable) begin
            class_code = BAT_OFF;
        end else if (mv_sat > i_cfg.full_threshold_mv) begin
            class_code = BAT_FULL;
        end else if (mv_sat > i_cfg.charge_threshold_mv) begin
            class_code = BAT_CHARGING;
        end else if (mv_sat > i_cfg.deep_threshold_mv
                     && mv_sat <= i_cfg.charge_threshold_mv) begin
            class_code = BAT_ATTN;
        end else if (mv_sat < i_cfg.absent_threshold_mv) begin
            class_code = BAT_NOT_CONNECTED;
        end else if (mv_sat <= i_cfg.deep_threshold_mv) begin
            class_code = BAT_DEPLETED;
        end else begin
            class_code = BAT_NOT_CONNECTED;
        end
    end

    always_comb begin
        if (close_win) begin
            n_sum  = '0;
            n_cnt  = '0;
            n_mv   = mv_sat;
            n_code = class_code;
        end else begin
            n_sum  = sum_all;
            n_cnt  = r_cnt + CNT_W'(1);
            n_mv   = r_mv;
            n_code = r_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_cnt  <= '0;
            r_mv   <= '0;
            r_code <= BAT_OFF;
        end else if (i_step) begin
            r_sum  <= n_sum;
            r_cnt  <= n_cnt;
            r_mv   <= n_mv;
            r_code <= n_code;
        end
    end

    assign o_bat.mv   = n_mv;
    assign o_bat.code = n_code;
    assign o_bat.done = close_win;

endmodule
